### design/dda_line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DDA_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

`define DDA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`else

`define DDA_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define DDA_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

### design/dda_pkg.sv
`default_nettype none

package dda_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COLOR_BITS     = 4;

   typedef enum logic {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

### design/dda_if.sv
`default_nettype none

interface dda_req_if #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [COORD_BITS-1:0]            start_x;
   logic [COORD_BITS-1:0]            start_y;
   logic [COORD_BITS-1:0]            end_x;
   logic [COORD_BITS-1:0]            end_y;
   logic [dda_pkg::COLOR_BITS-1:0]   color;

   modport source (output valid, operation, start_x, start_y, end_x, end_y, color,
                   input ready);
   modport sink   (input valid, operation, start_x, start_y, end_x, end_y, color,
                   output ready);
endinterface

interface dda_rsp_if #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();
   logic                             valid;
   logic                             ready;
   logic [COORD_BITS-1:0]            pixel_x;
   logic [COORD_BITS-1:0]            pixel_y;
   logic [dda_pkg::COLOR_BITS-1:0]   pixel_color;
   logic                             last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

`default_nettype wire

### design/dda_line_rasterizer.sv
// DDA line generator. A start transfer gives the endpoints and color of a line; a line of
// zero length answers with its single pixel in the next cycle, and any other line answers with
// pixel 0 once the one shared restoring divider has formed the x and then the y increment at
// one quotient bit per cycle. Each next-pixel transfer then answers with the following pixel,
// and the last of the step+1 pixels has last set. A next-pixel transfer while no line is
// active gives no result. A start abandons a line in progress, but requests are taken only
// while the divider is idle and no response is held back.
`default_nettype none

`include "dda_line_rasterizer_macros.svh"

module dda_line_rasterizer #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   dda_req_if.sink   req_ch,
   dda_rsp_if.source rsp_ch
);

   localparam int ACC_W = COORD_BITS + FRAC_BITS;
   localparam int CB    = dda_pkg::COLOR_BITS;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV_X = 3'b010,
      ST_DIV_Y = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic                  active_ff, active_in;
   logic                  launch_ff, launch_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [CB-1:0]         rsp_color_ff, rsp_color_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [ACC_W-1:0]      acc_x_ff, acc_x_in;
   logic [ACC_W-1:0]      acc_y_ff, acc_y_in;
   logic [ACC_W-1:0]      inc_x_ff, inc_x_in;
   logic [ACC_W-1:0]      inc_y_ff, inc_y_in;
   logic [COORD_BITS-1:0] left_ff, left_in;
   logic [CB-1:0]         color_ff, color_in;
   logic [COORD_BITS-1:0] adx_ff, adx_in;
   logic [COORD_BITS-1:0] ady_ff, ady_in;
   logic                  negx_ff, negx_in;
   logic                  negy_ff, negy_in;

   logic                  accept;
   logic                  neg_x, neg_y;
   logic [COORD_BITS-1:0] adx, ady, step;
   logic [ACC_W-1:0]      sum_x, sum_y;
   logic [ACC_W-1:0]      quo_ext, quo_neg;
   logic [COORD_BITS-1:0] div_mag;

   dda_pkg::div_stat_type div_stat;
   logic [FRAC_BITS:0]    quotient;

   dda_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (launch_ff),
      .magnitude (div_mag),
      .divisor   (left_ff),
      .stat      (div_stat),
      .quotient  (quotient)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign neg_x = req_ch.end_x < req_ch.start_x;
   assign neg_y = req_ch.end_y < req_ch.start_y;
   assign adx   = neg_x ? req_ch.start_x - req_ch.end_x : req_ch.end_x - req_ch.start_x;
   assign ady   = neg_y ? req_ch.start_y - req_ch.end_y : req_ch.end_y - req_ch.start_y;
   assign step  = (adx > ady) ? adx : ady;

   assign sum_x   = acc_x_ff + inc_x_ff;
   assign sum_y   = acc_y_ff + inc_y_ff;
   assign div_mag = (state_ff == ST_DIV_X) ? adx_ff : ady_ff;
   assign quo_ext = {{(ACC_W-FRAC_BITS-1){1'b0}}, quotient};
   assign quo_neg = '0 - quo_ext;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      launch_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      inc_x_in     = inc_x_ff;
      inc_y_in     = inc_y_ff;
      left_in      = left_ff;
      color_in     = color_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.operation == dda_pkg::OP_START) begin
                  color_in = req_ch.color;
                  acc_x_in = {req_ch.start_x, {FRAC_BITS{1'b0}}};
                  acc_y_in = {req_ch.start_y, {FRAC_BITS{1'b0}}};
                  adx_in   = adx;
                  ady_in   = ady;
                  negx_in  = neg_x;
                  negy_in  = neg_y;
                  left_in  = step;
                  if (step == '0) begin
                     inc_x_in     = '0;
                     inc_y_in     = '0;
                     active_in    = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = req_ch.start_x;
                     rsp_y_in     = req_ch.start_y;
                     rsp_color_in = req_ch.color;
                     rsp_last_in  = 1'b1;
                  end else begin
                     active_in = 1'b1;
                     launch_in = 1'b1;
                     state_in  = ST_DIV_X;
                  end
               end else if (active_ff) begin
                  acc_x_in     = sum_x;
                  acc_y_in     = sum_y;
                  left_in      = left_ff - 1'b1;
                  active_in    = left_ff != COORD_BITS'(1);
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = sum_x[ACC_W-1:FRAC_BITS];
                  rsp_y_in     = sum_y[ACC_W-1:FRAC_BITS];
                  rsp_color_in = color_ff;
                  rsp_last_in  = left_ff == COORD_BITS'(1);
               end
            end
         end
         ST_DIV_X: begin
            if (div_stat.done) begin
               inc_x_in  = negx_ff ? quo_neg : quo_ext;
               launch_in = 1'b1;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_stat.done) begin
               inc_y_in     = negy_ff ? quo_neg : quo_ext;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_x_in     = acc_x_ff[ACC_W-1:FRAC_BITS];
               rsp_y_in     = acc_y_ff[ACC_W-1:FRAC_BITS];
               rsp_color_in = color_ff;
               rsp_last_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      inc_x_ff     <= inc_x_in;
      inc_y_ff     <= inc_y_in;
      left_ff      <= left_in;
      color_ff     <= color_in;
      adx_ff       <= adx_in;
      ady_ff       <= ady_in;
      negx_ff      <= negx_in;
      negy_ff      <= negy_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_x     = rsp_x_ff;
   assign rsp_ch.pixel_y     = rsp_y_ff;
   assign rsp_ch.pixel_color = rsp_color_ff;
   assign rsp_ch.last        = rsp_last_ff;

   `DDA_ASSERT_IMPLIES(a_ready_div_idle, clock, reset, req_ch.ready, !div_stat.busy)
   `DDA_ASSERT_IMPLIES(a_done_in_div, clock, reset, div_stat.done, state_ff != ST_IDLE)
   `DDA_ASSERT_IMPLIES(a_last_ends_line, clock, reset, rsp_valid_ff && rsp_last_ff, !active_ff)
   `DDA_ASSERT_NEXT(a_launch_starts_div, clock, reset, launch_ff, div_stat.busy)

endmodule

`default_nettype wire

### design/dda_div.sv
`default_nettype none

module dda_div #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] magnitude,
   input  wire logic [COORD_BITS-1:0] divisor,
   output dda_pkg::div_stat_type      stat,
   output logic [FRAC_BITS:0]         quotient
);

   localparam int STEPS = COORD_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] dvs_ff, dvs_in;
   logic [STEPS-1:0]      num_ff, num_in;
   logic [FRAC_BITS:0]    quo_ff, quo_in;

   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, num_ff[STEPS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         rem_in  = '0;
         dvs_in  = divisor;
         num_in  = {magnitude, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         num_in = {num_ff[STEPS-2:0], 1'b0};
         quo_in = {quo_ff[FRAC_BITS-1:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign stat     = '{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

endmodule

`default_nettype wire
